// ===== hw/rtl/mdftb_pkg.sv =====
// Package for the data frame transmit builder.
// Holds the request and result structs, the queued frame descriptor and the
// header constants. Used by every module of the block.
package mdftb_pkg;

	localparam int unsigned MaxPayload   = 116;
	localparam int unsigned HdrLen       = 9;
	localparam int unsigned PayloadStart = 11;
	localparam int unsigned QueueDepth   = 4;

	localparam logic [7:0] FcLowAck    = 8'h61;
	localparam logic [7:0] FcLowNoAck  = 8'h41;
	localparam logic [7:0] FcHigh      = 8'h88;
	localparam logic [6:0] TxCtrlReg   = 7'h1B;
	localparam logic [7:0] TrigAck     = 8'h05;
	localparam logic [7:0] TrigNoAck   = 8'h01;
	localparam logic       KindFifo    = 1'b0;
	localparam logic       KindCtrl    = 1'b1;

	localparam logic [6:0] PayloadStartAddr = 7'(PayloadStart);
	localparam logic [6:0] PayloadEndAddr   = 7'(PayloadStart + MaxPayload);
	localparam logic [6:0] MaxPayloadLen    = 7'(MaxPayload);

	localparam logic [1:0] RegPanId   = 2'd0;
	localparam logic [1:0] RegSrcAddr = 2'd1;
	localparam logic [1:0] RegHoldSeq = 2'd2;

	typedef enum logic [3:0] {
		STEP_HDR_LEN   = 4'd0,
		STEP_FRM_LEN   = 4'd1,
		STEP_FC_LOW    = 4'd2,
		STEP_FC_HIGH   = 4'd3,
		STEP_SEQ       = 4'd4,
		STEP_PAN_LO    = 4'd5,
		STEP_PAN_HI    = 4'd6,
		STEP_DST_LO    = 4'd7,
		STEP_DST_HI    = 4'd8,
		STEP_SRC_LO    = 4'd9,
		STEP_SRC_HI    = 4'd10,
		STEP_PAYLOAD   = 4'd11,
		STEP_TRIGGER   = 4'd12
	} step_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        first_byte;
		logic        last_byte;
		logic [15:0] dest_address;
		logic [6:0]  payload_length;
		logic        ack_request;
	} in_item_t;

	typedef struct packed {
		logic       write_kind;
		logic [6:0] write_address;
		logic [7:0] write_data;
		logic       burst_end;
	} out_item_t;

	typedef struct packed {
		logic [15:0] pan_id;
		logic [15:0] source_address;
		logic        hold_sequence;
	} cfg_t;

	typedef struct packed {
		logic        first;
		logic        last;
		logic        has_byte;
		logic [7:0]  byte_value;
		logic [6:0]  byte_addr;
		logic [6:0]  length;
		logic        ack;
		logic        trig_ack;
		logic [7:0]  seq;
		logic [15:0] dest;
	} desc_t;

endpackage

// ===== hw/rtl/mdftb_front.sv =====
// Front end of the frame builder: accepts requests, turns each that needs
// a write into a frame descriptor. Keeps the sequence number, FIFO pointer
// and frame ack. Depends on mdftb_pkg.
module mdftb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  mdftb_pkg::in_item_t in_data,
	input  logic              hold_sequence,
	input  logic              queue_full,
	output logic              push,
	output mdftb_pkg::desc_t  push_desc
);
	import mdftb_pkg::*;

	logic [7:0] seq_q;
	logic [6:0] ptr_q;
	logic       frame_ack_q;
	logic       accept;
	logic [6:0] ptr_eff;
	logic       has_byte;
	logic       ack_eff;

	assign accept   = in_valid && !queue_full;
	assign ptr_eff  = in_data.first_byte ? PayloadStartAddr : ptr_q;
	assign has_byte = ptr_eff < PayloadEndAddr;
	assign ack_eff  = in_data.first_byte ? in_data.ack_request : frame_ack_q;

	always_comb begin
		push_desc.first      = in_data.first_byte;
		push_desc.last       = in_data.last_byte;
		push_desc.has_byte   = has_byte;
		push_desc.byte_value = in_data.payload_byte;
		push_desc.byte_addr  = ptr_eff;
		push_desc.length     = (in_data.payload_length > MaxPayloadLen) ?
			MaxPayloadLen : in_data.payload_length;
		push_desc.ack        = in_data.ack_request;
		push_desc.trig_ack   = ack_eff;
		push_desc.seq        = seq_q;
		push_desc.dest       = in_data.dest_address;
	end

	assign push = accept && (in_data.first_byte || has_byte || in_data.last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= '0;
			ptr_q       <= '0;
			frame_ack_q <= 1'b0;
		end else if (accept) begin
			frame_ack_q <= ack_eff;
			ptr_q       <= has_byte ? ptr_eff + 7'd1 : ptr_eff;
			if (in_data.first_byte && !hold_sequence) begin
				seq_q <= seq_q + 8'd1;
			end
		end
	end

endmodule

// ===== hw/rtl/mdftb_queue.sv =====
// Short descriptor queue between the front and back ends of the builder.
// Register based, one push and one pop per cycle. Depends on mdftb_pkg.
module mdftb_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mdftb_pkg::desc_t push_desc,
	input  logic             pop,
	output logic             full,
	output logic             head_valid,
	output mdftb_pkg::desc_t head_desc
);
	import mdftb_pkg::*;

	localparam int unsigned PtrW = $clog2(QueueDepth);
	localparam int unsigned CntW = $clog2(QueueDepth + 1);

	desc_t            mem_q [QueueDepth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = count_q == CntW'(QueueDepth);
	assign head_valid = count_q != '0;
	assign head_desc  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/mdftb_back.sv =====
// Back end of the frame builder: steps through the header, payload and
// trigger writes of the descriptor at the queue head into an output register.
// Depends on mdftb_pkg.
module mdftb_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mdftb_pkg::cfg_t      cfg,
	input  logic                 head_valid,
	input  mdftb_pkg::desc_t     head_desc,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mdftb_pkg::out_item_t out_data
);
	import mdftb_pkg::*;

	step_t     step_q;
	logic      mid_q;
	step_t     step_eff;
	step_t     step_start;
	step_t     step_next;
	logic      done;
	logic      load;
	logic      emit;
	logic      out_valid_q;
	out_item_t out_q;
	out_item_t res;

	always_comb begin
		if (head_desc.first) begin
			step_start = STEP_HDR_LEN;
		end else if (head_desc.has_byte) begin
			step_start = STEP_PAYLOAD;
		end else begin
			step_start = STEP_TRIGGER;
		end
	end

	assign step_eff = mid_q ? step_q : step_start;

	always_comb begin
		res.write_kind    = KindFifo;
		res.write_address = 7'(step_eff);
		res.write_data    = 8'h00;
		step_next         = step_t'(step_eff + 4'd1);
		done              = 1'b0;
		unique case (step_eff)
			STEP_HDR_LEN: res.write_data = 8'(HdrLen);
			STEP_FRM_LEN: res.write_data = {1'b0, head_desc.length} + 8'(HdrLen);
			STEP_FC_LOW:  res.write_data = head_desc.ack ? FcLowAck : FcLowNoAck;
			STEP_FC_HIGH: res.write_data = FcHigh;
			STEP_SEQ:     res.write_data = head_desc.seq;
			STEP_PAN_LO:  res.write_data = cfg.pan_id[7:0];
			STEP_PAN_HI:  res.write_data = cfg.pan_id[15:8];
			STEP_DST_LO:  res.write_data = head_desc.dest[7:0];
			STEP_DST_HI:  res.write_data = head_desc.dest[15:8];
			STEP_SRC_LO:  res.write_data = cfg.source_address[7:0];
			STEP_SRC_HI: begin
				res.write_data = cfg.source_address[15:8];
				if (head_desc.has_byte) begin
					step_next = STEP_PAYLOAD;
				end else if (head_desc.last) begin
					step_next = STEP_TRIGGER;
				end else begin
					done = 1'b1;
				end
			end
			STEP_PAYLOAD: begin
				res.write_address = head_desc.byte_addr;
				res.write_data    = head_desc.byte_value;
				step_next         = STEP_TRIGGER;
				done              = !head_desc.last;
			end
			STEP_TRIGGER: begin
				res.write_kind    = KindCtrl;
				res.write_address = TxCtrlReg;
				res.write_data    = head_desc.trig_ack ? TrigAck : TrigNoAck;
				done              = 1'b1;
			end
			default: begin
				done = 1'b1;
			end
		endcase
		res.burst_end = done;
	end

	assign load = !out_valid_q || !out_stall;
	assign emit = load && head_valid;
	assign pop  = emit && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			mid_q       <= 1'b0;
			step_q      <= STEP_HDR_LEN;
		end else begin
			if (load) begin
				out_valid_q <= head_valid;
			end
			if (emit) begin
				mid_q  <= !done;
				step_q <= step_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== hw/rtl/mac_data_frame_tx_builder_core.sv =====
// Top level of the data frame transmit builder: configuration registers,
// front end, descriptor queue and back end. Depends on mdftb_pkg and the
// mdftb_front, mdftb_queue and mdftb_back modules.
//
//  Port group  Direction  Handshake          Contents
//  in_*        request    in_valid/in_stall  payload byte, frame start/end flags
//  out_*       result     out_valid/out_stall FIFO or control register write
//  cfg_*       write      cfg_wr_en          PAN ID, source address, hold flag
//
// While out_stall is low, a payload byte gives one write per cycle; a frame start
// gives 11 header writes before its byte and a frame end one trigger write after
// it, one per cycle, set by the single write port of the back end.
// The four-entry queue lets requests arrive while the back end works through
// a header. Reset clears the counters, queue and configuration at once.
// out_stall holds the output register; in_stall rises only when the queue is full.
module mac_data_frame_tx_builder_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mdftb_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mdftb_pkg::out_item_t out_data,
	input  logic                 cfg_wr_en,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_wdata
);
	import mdftb_pkg::*;

	cfg_t  cfg_q;
	logic  push;
	desc_t push_desc;
	logic  pop;
	logic  full;
	logic  head_valid;
	desc_t head_desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				RegPanId:   cfg_q.pan_id         <= cfg_wdata;
				RegSrcAddr: cfg_q.source_address <= cfg_wdata;
				RegHoldSeq: cfg_q.hold_sequence  <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign in_stall = full;

	mdftb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_data      (in_data),
		.hold_sequence(cfg_q.hold_sequence),
		.queue_full   (full),
		.push         (push),
		.push_desc    (push_desc)
	);

	mdftb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.full      (full),
		.head_valid(head_valid),
		.head_desc (head_desc)
	);

	mdftb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head_valid(head_valid),
		.head_desc (head_desc),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Testbench for mac_data_frame_tx_builder_core: drives payload byte requests and register writes,
// predicts every FIFO and control write in a local model and checks each result as it leaves.
// Depends on mdftb_pkg and the RTL of the block only.
module tb;
	import mdftb_pkg::*;

	localparam int unsigned CycleLimit   = 400000;
	localparam int unsigned SettleCycles = 64;
	localparam int unsigned HoldOffLen   = 300;
	localparam int unsigned MaxReports   = 40;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	logic      cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;

	// Local copy of the builder state and its registers.
	logic [15:0] model_pan;
	logic [15:0] model_src;
	logic        model_hold;
	logic [7:0]  model_seq;
	logic [6:0]  model_ptr;
	logic        model_ack;

	out_item_t pending_writes[$];
	out_item_t want;
	int unsigned errors;
	int unsigned cycles;
	bit sender_idle_en;
	bit receiver_idle_en;
	bit hold_pending;
	int unsigned hold_left;

	mac_data_frame_tx_builder_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int unsigned exp_v,
			input int unsigned got_v);
		if (errors < MaxReports) begin
			$display("[%0d] mismatch on %s: expected 0x%0h, got 0x%0h", cycles, what, exp_v, got_v);
		end
		errors++;
	endtask

	function automatic out_item_t fifo_write(input logic [6:0] addr, input logic [7:0] data);
		out_item_t w;
		w.write_kind    = KindFifo;
		w.write_address = addr;
		w.write_data    = data;
		w.burst_end     = 1'b0;
		return w;
	endfunction

	task automatic build_frame_writes(input in_item_t req);
		out_item_t burst[$];
		out_item_t trig;
		logic [6:0] len;
		len = req.payload_length;
		if (req.first_byte) begin
			if (len > MaxPayloadLen) len = MaxPayloadLen;
			model_ack = req.ack_request;
			burst.push_back(fifo_write(7'(STEP_HDR_LEN), 8'(HdrLen)));
			burst.push_back(fifo_write(7'(STEP_FRM_LEN), 8'(HdrLen) + 8'(len)));
			burst.push_back(fifo_write(7'(STEP_FC_LOW), req.ack_request ? FcLowAck : FcLowNoAck));
			burst.push_back(fifo_write(7'(STEP_FC_HIGH), FcHigh));
			burst.push_back(fifo_write(7'(STEP_SEQ), model_seq));
			if (!model_hold) model_seq = model_seq + 8'd1;
			burst.push_back(fifo_write(7'(STEP_PAN_LO), model_pan[7:0]));
			burst.push_back(fifo_write(7'(STEP_PAN_HI), model_pan[15:8]));
			burst.push_back(fifo_write(7'(STEP_DST_LO), req.dest_address[7:0]));
			burst.push_back(fifo_write(7'(STEP_DST_HI), req.dest_address[15:8]));
			burst.push_back(fifo_write(7'(STEP_SRC_LO), model_src[7:0]));
			burst.push_back(fifo_write(7'(STEP_SRC_HI), model_src[15:8]));
			model_ptr = PayloadStartAddr;
		end
		if (model_ptr < PayloadEndAddr) begin
			burst.push_back(fifo_write(model_ptr, req.payload_byte));
			model_ptr = model_ptr + 7'd1;
		end
		if (req.last_byte) begin
			trig.write_kind    = KindCtrl;
			trig.write_address = TxCtrlReg;
			trig.write_data    = model_ack ? TrigAck : TrigNoAck;
			trig.burst_end     = 1'b0;
			burst.push_back(trig);
		end
		if (burst.size() > 0) burst[burst.size() - 1].burst_end = 1'b1;
		foreach (burst[i]) pending_writes.push_back(burst[i]);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_writes.size() == 0) begin
				report_mismatch("unexpected write", 0, out_data);
			end else begin
				want = pending_writes.pop_front();
				if (out_data.write_kind !== want.write_kind)
					report_mismatch("write_kind", want.write_kind, out_data.write_kind);
				if (out_data.write_address !== want.write_address)
					report_mismatch("write_address", want.write_address, out_data.write_address);
				if (out_data.write_data !== want.write_data)
					report_mismatch("write_data", want.write_data, out_data.write_data);
				if (out_data.burst_end !== want.burst_end)
					report_mismatch("burst_end", want.burst_end, out_data.burst_end);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left = HoldOffLen;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= receiver_idle_en && ($urandom_range(0, 99) < 27);
			end
		end
	end

	task automatic send_byte_request(input in_item_t req);
		while (sender_idle_en && $urandom_range(0, 99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		build_frame_writes(req);
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_fifo_quiet(input bit settle);
		in_valid <= 1'b0;
		while (pending_writes.size() != 0) @(posedge clk);
		if (settle) repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_config(input logic [1:0] idx, input logic [15:0] value);
		wait_fifo_quiet(1'b1);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			RegPanId:   model_pan = value;
			RegSrcAddr: model_src = value;
			RegHoldSeq: model_hold = value[0];
			default: ;
		endcase
	endtask

	function automatic in_item_t make_request(input logic [7:0] b, input logic first,
			input logic last, input logic [15:0] dest, input logic [6:0] len, input logic ack);
		in_item_t r;
		r.payload_byte   = b;
		r.first_byte     = first;
		r.last_byte      = last;
		r.dest_address   = dest;
		r.payload_length = len;
		r.ack_request    = ack;
		return r;
	endfunction

	function automatic in_item_t random_request();
		return make_request(8'($urandom), 1'($urandom), 1'($urandom), 16'($urandom),
			7'($urandom), 1'($urandom));
	endfunction

	task automatic send_frame(input logic [15:0] dest, input logic [6:0] len, input logic ack,
			input int nbytes, input bit close);
		in_item_t req;
		for (int i = 0; i < nbytes; i++) begin
			req = random_request();
			req.first_byte = (i == 0);
			req.last_byte  = close && (i == nbytes - 1);
			if (i == 0) begin
				req.dest_address   = dest;
				req.payload_length = len;
				req.ack_request    = ack;
			end
			send_byte_request(req);
		end
	endtask

	// Bytes that arrive before any frame has been started, after reset.
	task automatic test_stray_bytes();
		send_byte_request(make_request(8'h00, 1'b0, 1'b0, 16'hFFFF, 7'h7F, 1'b1));
		send_byte_request(make_request(8'hFF, 1'b0, 1'b1, 16'h0000, 7'h00, 1'b0));
	endtask

	task automatic test_frame_basics();
		send_byte_request(make_request(8'hFF, 1'b1, 1'b1, 16'hFFFF, 7'd1, 1'b1));
		send_byte_request(make_request(8'h00, 1'b1, 1'b0, 16'h0000, 7'd0, 1'b0));
		send_byte_request(make_request(8'h5A, 1'b0, 1'b0, 16'h1234, 7'd3, 1'b1));
		send_byte_request(make_request(8'hA5, 1'b0, 1'b1, 16'h4321, 7'd9, 1'b1));
		send_byte_request(make_request(8'h3C, 1'b0, 1'b0, 16'h0F0F, 7'd2, 1'b0));
		send_byte_request(make_request(8'h81, 1'b1, 1'b0, 16'h1234, 7'd127, 1'b1));
		send_byte_request(make_request(8'h7E, 1'b0, 1'b1, 16'h00FF, 7'd5, 1'b0));
		send_byte_request(make_request(8'hC3, 1'b1, 1'b1, 16'hABCD, 7'd116, 1'b0));
	endtask

	task automatic test_config_extremes();
		write_config(RegPanId, 16'hFFFF);
		write_config(RegSrcAddr, 16'hFFFF);
		write_config(RegHoldSeq, 16'h0001);
		send_frame(16'h8001, 7'd2, 1'b1, 2, 1'b1);
		send_frame(16'h0001, 7'd1, 1'b0, 1, 1'b1);
		write_config(RegPanId, 16'h0000);
		write_config(RegSrcAddr, 16'h0000);
		write_config(RegHoldSeq, 16'h0000);
		send_frame(16'hFF00, 7'd1, 1'b1, 1, 1'b1);
	endtask

	// A full-length frame followed by more bytes than fit, then one more stray byte.
	task automatic test_payload_overflow();
		write_config(RegPanId, 16'($urandom));
		write_config(RegSrcAddr, 16'($urandom));
		send_frame(16'($urandom), MaxPayloadLen, 1'b1, MaxPayload + 4, 1'b1);
		send_byte_request(make_request(8'($urandom), 1'b0, 1'b0, 16'($urandom), 7'($urandom),
			1'($urandom)));
	endtask

	function automatic int pick_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) return $urandom_range(1, 8);
		if (roll < 95) return $urandom_range(9, 40);
		return $urandom_range(41, 116);
	endfunction

	task automatic random_traffic(input int n_items);
		int sent;
		int roll;
		int len;
		int nbytes;
		sent = 0;
		while (sent < n_items) begin
			roll = $urandom_range(0, 99);
			if (roll < 80) begin
				len = pick_length();
				if (len > n_items - sent + 4) len = $urandom_range(1, 4);
				send_frame(16'($urandom), 7'(len), 1'($urandom), len, 1'b1);
				sent += len;
			end else if (roll < 90) begin
				nbytes = $urandom_range(1, 12);
				send_frame(16'($urandom), 7'($urandom), 1'($urandom), nbytes, 1'($urandom));
				sent += nbytes;
			end else begin
				send_byte_request(random_request());
				sent++;
			end
		end
	endtask

	task automatic test_random_traffic();
		write_config(RegPanId, 16'($urandom));
		write_config(RegSrcAddr, 16'($urandom));
		write_config(RegHoldSeq, 16'h0000);
		random_traffic(45);

		// The receiver holds off while requests keep coming, so the queue fills up.
		sender_idle_en = 1'b0;
		hold_pending = 1'b1;
		random_traffic(30);
		sender_idle_en = 1'b1;
		wait_fifo_quiet(1'b0);

		write_config(RegPanId, 16'hFFFF);
		write_config(RegSrcAddr, 16'h0000);
		write_config(RegHoldSeq, 16'h0001);
		sender_idle_en = 1'b0;
		receiver_idle_en = 1'b0;
		random_traffic(30);
		sender_idle_en = 1'b1;
		receiver_idle_en = 1'b1;

		write_config(RegPanId, 16'h0000);
		write_config(RegSrcAddr, 16'hFFFF);
		write_config(RegHoldSeq, 16'h0000);
		random_traffic(30);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		errors = 0;
		cycles = 0;
		sender_idle_en = 1'b1;
		receiver_idle_en = 1'b1;
		hold_pending = 1'b0;
		hold_left = 0;
		model_pan = '0;
		model_src = '0;
		model_hold = 1'b0;
		model_seq = '0;
		model_ptr = '0;
		model_ack = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_stray_bytes();
		test_frame_basics();
		test_config_extremes();
		test_payload_overflow();
		test_random_traffic();

		wait_fifo_quiet(1'b1);
		if (errors == 0 && pending_writes.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d writes never seen", errors, pending_writes.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/mdftb_pkg.sv
hw/rtl/mdftb_front.sv
hw/rtl/mdftb_queue.sv
hw/rtl/mdftb_back.sv
hw/rtl/mac_data_frame_tx_builder_core.sv
dv/tb.sv
